>>> sv/dag_edge_insert_cycle_check_top_defines.svh
// Assertion macros used by the checker file.
// Depends on nothing.
`ifndef DAG_EDGE_INSERT_CYCLE_CHECK_TOP_DEFINES_SVH
`define DAG_EDGE_INSERT_CYCLE_CHECK_TOP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define DAG_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define DAG_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> sv/dag_pkg.sv
// Package for the graph cycle check block: sizes, mode and status codes, command and status types.
// Depends on nothing.
package dag_pkg;
  localparam int MaxNodes = 32;
  localparam int MaxEdges = 64;
  localparam int KeyWidth = 64;
  localparam int NodeIdxW = $clog2(MaxNodes);
  localparam int NodeCntW = $clog2(MaxNodes + 1);
  localparam int EdgeIdxW = $clog2(MaxEdges);
  localparam int EdgeCntW = $clog2(MaxEdges + 1);
  localparam int EdgeW    = 2 * NodeIdxW;

  localparam logic [1:0] ModeClear = 2'd0;
  localparam logic [1:0] ModeNode  = 2'd1;
  localparam logic [1:0] ModeEdge  = 2'd2;
  localparam logic [1:0] ModeNop   = 2'd3;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StExists   = 3'd1;
  localparam logic [2:0] StFull     = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StCycle    = 3'd4;

  typedef struct packed {
    logic load;         // latch item, clear search results
    logic clear_graph;  // zero counts
    logic key_step;     // compare key RAM word with both keys
    logic key_rd;       // issue key RAM read at key pointer
    logic add_node;     // append first key
    logic walk_init;    // seed reachability walk
    logic walk_pop;     // pop stack and start edge scan
    logic edge_rd;      // issue edge RAM read at edge pointer
    logic edge_step;    // consume edge RAM word
    logic add_edge;     // append edge
  } dag_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       key_last;    // key pointer at last stored node
    logic       nodes_zero;
    logic       found1;
    logic       found2;
    logic       self_edge;
    logic       nodes_full;
    logic       edges_zero;
    logic       edge_last;
    logic       edges_full;
    logic       stack_empty;
    logic       hit;         // walk reached target
  } dag_sts_t;
endpackage

>>> sv/dag_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
module dag_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/dag_datapath.sv
// Datapath: key and edge RAMs, counts, search pointers, walk stack and seen bits.
// Depends on dag_pkg and dag_ram.
module dag_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  dag_pkg::dag_cmd_t            cmd,
  output dag_pkg::dag_sts_t            sts,
  input  logic [1:0]                   mode,
  input  logic [63:0]                  first_key,
  input  logic [63:0]                  second_key
);
  logic [1:0]                    mode_r;
  logic [dag_pkg::KeyWidth-1:0]  k1, k2;
  logic [dag_pkg::NodeCntW-1:0]  node_count;
  logic [dag_pkg::EdgeCntW-1:0]  edge_count;
  logic [dag_pkg::NodeIdxW-1:0]  kptr, kptr_rd, idx1, idx2, cur;
  logic [dag_pkg::EdgeIdxW-1:0]  eptr, eptr_rd;
  logic                          found1, found2, hit;
  logic [dag_pkg::MaxNodes-1:0]  seen;
  logic [dag_pkg::NodeIdxW-1:0]  stack [dag_pkg::MaxNodes];
  logic [dag_pkg::NodeCntW-1:0]  top;
  logic [dag_pkg::KeyWidth-1:0]  key_rdata;
  logic [dag_pkg::EdgeW-1:0]     edge_rdata;
  logic [dag_pkg::NodeIdxW-1:0]  e_pre, e_dep;

  dag_ram #(.Width(dag_pkg::KeyWidth), .Depth(dag_pkg::MaxNodes)) u_keys (
    .clk(clk), .we(cmd.add_node), .waddr(node_count[dag_pkg::NodeIdxW-1:0]),
    .wdata(k1), .raddr(kptr_rd), .rdata(key_rdata));

  dag_ram #(.Width(dag_pkg::EdgeW), .Depth(dag_pkg::MaxEdges)) u_edges (
    .clk(clk), .we(cmd.add_edge), .waddr(edge_count[dag_pkg::EdgeIdxW-1:0]),
    .wdata({idx1, idx2}), .raddr(eptr_rd), .rdata(edge_rdata));

  assign e_pre = edge_rdata[dag_pkg::EdgeW-1:dag_pkg::NodeIdxW];
  assign e_dep = edge_rdata[dag_pkg::NodeIdxW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
      edge_count <= '0;
    end else begin
      if (cmd.clear_graph) begin
        node_count <= '0;
        edge_count <= '0;
      end
      if (cmd.add_node) begin
        node_count <= node_count + 1'b1;
      end
      if (cmd.add_edge) begin
        edge_count <= edge_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode;
      k1     <= first_key[dag_pkg::KeyWidth-1:0];
      k2     <= second_key[dag_pkg::KeyWidth-1:0];
      found1 <= 1'b0;
      found2 <= 1'b0;
      kptr   <= '0;
      hit    <= 1'b0;
    end
    if (cmd.key_rd) begin
      kptr_rd <= kptr;
      kptr    <= kptr + 1'b1;
    end
    if (cmd.key_step) begin
      if (key_rdata == k1 && !found1) begin
        found1 <= 1'b1;
        idx1   <= kptr_rd;
      end
      if (key_rdata == k2 && !found2) begin
        found2 <= 1'b1;
        idx2   <= kptr_rd;
      end
    end
    if (cmd.walk_init) begin
      seen        <= dag_pkg::MaxNodes'(1) << idx2;
      stack[0]    <= idx2;
      top         <= dag_pkg::NodeCntW'(1);
    end
    if (cmd.walk_pop) begin
      cur  <= stack[top[dag_pkg::NodeIdxW-1:0] - 1'b1];
      top  <= top - 1'b1;
    end
    if (cmd.edge_rd) begin
      if (cmd.walk_pop) begin
        eptr_rd <= '0;
        eptr    <= dag_pkg::EdgeIdxW'(1);
      end else begin
        eptr_rd <= eptr;
        eptr    <= eptr + 1'b1;
      end
    end
    if (cmd.edge_step) begin
      if (e_pre == cur && !seen[e_dep]) begin
        if (e_dep == idx1) begin
          hit <= 1'b1;
        end
        seen[e_dep] <= 1'b1;
        stack[top[dag_pkg::NodeIdxW-1:0]] <= e_dep;
        top <= top + 1'b1;
      end
    end
  end

  always_comb begin
    sts.mode        = mode_r;
    sts.key_last    = (dag_pkg::NodeCntW'(kptr_rd) + 1'b1) == node_count;
    sts.nodes_zero  = node_count == '0;
    sts.found1      = found1;
    sts.found2      = found2;
    sts.self_edge   = idx1 == idx2;
    sts.nodes_full  = node_count == dag_pkg::NodeCntW'(dag_pkg::MaxNodes);
    sts.edges_zero  = edge_count == '0;
    sts.edge_last   = (dag_pkg::EdgeCntW'(eptr_rd) + 1'b1) == edge_count;
    sts.edges_full  = edge_count == dag_pkg::EdgeCntW'(dag_pkg::MaxEdges);
    sts.stack_empty = top == '0;
    sts.hit         = hit;
  end
endmodule

>>> sv/dag_ctrl.sv
// Controller: sequences key search, reachability walk and table updates per item.
// Depends on dag_pkg.
module dag_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  output dag_pkg::dag_cmd_t cmd,
  input  dag_pkg::dag_sts_t sts
);
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DISP   = 9'b000000010,
    S_KRD    = 9'b000000100,
    S_KCMP   = 9'b000001000,
    S_DECIDE = 9'b000010000,
    S_POP    = 9'b000100000,
    S_ERD    = 9'b001000000,
    S_ECMP   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t     state, state_next;
  logic [2:0] res, res_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
        status    <= res;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
    res <= res_next;
  end

  always_comb begin
    state_next   = state;
    res_next     = res;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          res_next   = dag_pkg::StOk;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.mode == dag_pkg::ModeClear) begin
          cmd.clear_graph = 1'b1;
          state_next      = S_DONE;
        end else if (sts.mode == dag_pkg::ModeNode || sts.mode == dag_pkg::ModeEdge) begin
          if (sts.nodes_zero) begin
            state_next = S_DECIDE;
          end else begin
            cmd.key_rd = 1'b1;
            state_next = S_KRD;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_KRD: state_next = S_KCMP;
      S_KCMP: begin
        cmd.key_step = 1'b1;
        if (sts.key_last) begin
          state_next = S_DECIDE;
        end else begin
          cmd.key_rd = 1'b1;
          state_next = S_KRD;
        end
      end
      S_DECIDE: begin
        if (sts.mode == dag_pkg::ModeNode) begin
          if (sts.found1) begin
            res_next = dag_pkg::StExists;
          end else if (sts.nodes_full) begin
            res_next = dag_pkg::StFull;
          end else begin
            cmd.add_node = 1'b1;
          end
          state_next = S_DONE;
        end else if (!sts.found1 || !sts.found2) begin
          res_next   = dag_pkg::StNotFound;
          state_next = S_DONE;
        end else if (sts.self_edge) begin
          res_next   = dag_pkg::StCycle;
          state_next = S_DONE;
        end else begin
          cmd.walk_init = 1'b1;
          state_next    = S_POP;
        end
      end
      S_POP: begin
        if (sts.hit) begin
          res_next   = dag_pkg::StCycle;
          state_next = S_DONE;
        end else if (sts.stack_empty || sts.edges_zero) begin
          if (sts.edges_full) begin
            res_next = dag_pkg::StFull;
          end else begin
            cmd.add_edge = 1'b1;
          end
          state_next = S_DONE;
        end else begin
          cmd.walk_pop = 1'b1;
          cmd.edge_rd  = 1'b1;
          state_next   = S_ERD;
        end
      end
      S_ERD: begin
        state_next = S_ECMP;
      end
      S_ECMP: begin
        cmd.edge_step = 1'b1;
        if (sts.edge_last) begin
          state_next = S_POP;
        end else begin
          cmd.edge_rd = 1'b1;
          state_next  = S_ERD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

>>> sv/dag_edge_insert_cycle_check_top.sv
// Top level of the graph cycle check block: controller plus datapath.
// Depends on dag_pkg, dag_ctrl, dag_datapath.
//
//   channel | signals                                  | dir
//   in      | in_valid in_stall mode first_key second_key | to block
//   out     | out_valid out_stall status               | from block
//
// One item at a time: clear goes straight from dispatch to done, add node scans the stored
// keys, and add edge also scans every stored edge for each node that the reachability walk visits.
// The key RAM and edge RAM read ports set the pace: each word takes a read state and a compare state.
// Synchronous reset empties the graph at once. in_stall is high while busy;
// a stalled result holds until taken, and the next result waits for it.
module dag_edge_insert_cycle_check_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [63:0] first_key,
  input  logic [63:0] second_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status
);
  dag_pkg::dag_cmd_t cmd;
  dag_pkg::dag_sts_t sts;

  dag_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .cmd(cmd), .sts(sts));

  dag_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .mode(mode),
    .first_key(first_key), .second_key(second_key));
endmodule

>>> sv/dag_checker.sv
// Port checker for the graph cycle check block, bound to the top level.
// Depends on dag_edge_insert_cycle_check_top_defines.svh and dag_pkg.
`include "dag_edge_insert_cycle_check_top_defines.svh"
module dag_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] status
);
  `DAG_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "idle after accept")
  `DAG_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status), "result dropped")
  `DAG_ASSERT_IMP(a_status_code, clk, rst, out_valid, status <= dag_pkg::StCycle, "bad status")
  `DAG_ASSERT_NXT(a_no_out_on_accept, clk, rst, in_valid && !in_stall, !out_valid || $past(out_valid), "early result")
endmodule

bind dag_edge_insert_cycle_check_top dag_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status(status));

>>> test/tb.sv
// Testbench for dag_edge_insert_cycle_check_top: directed table, then random graph builds.
// Depends on dag_pkg and the block; predicts status with its own graph copy.
`timescale 1ns / 100ps
module tb;
  localparam int TableLen = 22;
  localparam int NoCheck = 7;
  localparam int WatchLimit = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = dag_pkg::ModeClear;
  logic [63:0] first_key = '0;
  logic [63:0] second_key = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;

  dag_edge_insert_cycle_check_top u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [63:0] graph_keys[dag_pkg::MaxNodes];
  int          graph_nodes;
  int          edge_pre[dag_pkg::MaxEdges];
  int          edge_dep[dag_pkg::MaxEdges];
  int          graph_edges;
  logic [2:0]  status_q[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          stim_done = 1'b0;
  logic [63:0] pool[48];

  task automatic report(input string what, input logic [2:0] got, input logic [2:0] want);
    $display("tb: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int node_index(input logic [63:0] key);
    for (int i = 0; i < graph_nodes; i++)
      if (graph_keys[i] == key) return i;
    return -1;
  endfunction

  function automatic bit reaches(input int from, input int to);
    bit seen[dag_pkg::MaxNodes];
    int stack[$];
    int cur;
    if (from == to) return 1'b1;
    seen = '{default: 1'b0};
    seen[from] = 1'b1;
    stack.push_back(from);
    while (stack.size() > 0) begin
      cur = stack.pop_back();
      for (int e = 0; e < graph_edges; e++) begin
        if (edge_pre[e] == cur && !seen[edge_dep[e]]) begin
          if (edge_dep[e] == to) return 1'b1;
          seen[edge_dep[e]] = 1'b1;
          stack.push_back(edge_dep[e]);
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [2:0] predict_status(input logic [1:0] m, input logic [63:0] k1,
                                               input logic [63:0] k2);
    int p;
    int d;
    case (m)
      dag_pkg::ModeClear: begin
        graph_nodes = 0;
        graph_edges = 0;
      end
      dag_pkg::ModeNode: begin
        if (node_index(k1) >= 0) return dag_pkg::StExists;
        if (graph_nodes >= dag_pkg::MaxNodes) return dag_pkg::StFull;
        graph_keys[graph_nodes++] = k1;
      end
      dag_pkg::ModeEdge: begin
        p = node_index(k1);
        d = node_index(k2);
        if (p < 0 || d < 0) return dag_pkg::StNotFound;
        if (reaches(d, p)) return dag_pkg::StCycle;
        if (graph_edges >= dag_pkg::MaxEdges) return dag_pkg::StFull;
        edge_pre[graph_edges] = p;
        edge_dep[graph_edges] = d;
        graph_edges++;
      end
      default: ;
    endcase
    return dag_pkg::StOk;
  endfunction

  task automatic send(input logic [1:0] m, input logic [63:0] k1, input logic [63:0] k2,
                      input int want);
    logic [2:0] pred;
    int gap;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pred = predict_status(m, k1, k2);
    if (want != NoCheck && pred != 3'(want)) report("table", pred, 3'(want));
    status_q.push_back(pred);
    in_valid <= 1'b1;
    mode <= m;
    first_key <= k1;
    second_key <= k2;
    do @(posedge clk); while (in_stall);
  endtask

  typedef struct {
    logic [1:0]  m;
    logic [63:0] k1;
    logic [63:0] k2;
    int          want;
  } stim_row_t;

  stim_row_t stim_table[TableLen] = '{
    '{dag_pkg::ModeEdge,  64'd1, 64'd2, dag_pkg::StNotFound},
    '{dag_pkg::ModeNode,  64'd0, 64'd0, dag_pkg::StOk},
    '{dag_pkg::ModeNode,  '1,    64'd0, dag_pkg::StOk},
    '{dag_pkg::ModeNode,  64'd0, 64'd5, dag_pkg::StExists},
    '{dag_pkg::ModeEdge,  64'd0, 64'd0, dag_pkg::StCycle},
    '{dag_pkg::ModeEdge,  64'd0, '1,    dag_pkg::StOk},
    '{dag_pkg::ModeEdge,  64'd0, '1,    dag_pkg::StOk},
    '{dag_pkg::ModeEdge,  '1,    64'd0, dag_pkg::StCycle},
    '{dag_pkg::ModeEdge,  64'd0, 64'd9, dag_pkg::StNotFound},
    '{dag_pkg::ModeEdge,  64'd9, 64'd0, dag_pkg::StNotFound},
    '{dag_pkg::ModeNode,  64'h5555_5555_5555_5555, 64'd0, dag_pkg::StOk},
    '{dag_pkg::ModeEdge,  '1, 64'h5555_5555_5555_5555, dag_pkg::StOk},
    '{dag_pkg::ModeEdge,  64'h5555_5555_5555_5555, 64'd0, dag_pkg::StCycle},
    '{dag_pkg::ModeNop,   64'd7, 64'd8, dag_pkg::StOk},
    '{dag_pkg::ModeNode,  64'd7, 64'd0, NoCheck},
    '{dag_pkg::ModeEdge,  64'd7, 64'd0, NoCheck},
    '{dag_pkg::ModeClear, 64'd0, 64'd0, dag_pkg::StOk},
    '{dag_pkg::ModeEdge,  64'd0, '1,    dag_pkg::StNotFound},
    '{dag_pkg::ModeNode,  64'h8000_0000_0000_0000, '1, dag_pkg::StOk},
    '{dag_pkg::ModeNode,  64'hAAAA_AAAA_AAAA_AAAA, '1, dag_pkg::StOk},
    '{dag_pkg::ModeEdge,  64'h8000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA, dag_pkg::StOk},
    '{dag_pkg::ModeClear, '1, '1, dag_pkg::StOk}
  };

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          report("unexpected", status, dag_pkg::StOk);
        end else begin
          if (status !== status_q[0]) report("status", status, status_q[0]);
          void'(status_q.pop_front());
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WatchLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic random_key(output logic [63:0] k);
    if ($urandom_range(0, 9) == 0) k = {$urandom, $urandom};
    else k = pool[$urandom_range(0, 47)];
  endtask

  initial begin
    logic [63:0] k1;
    logic [63:0] k2;
    int pick;
    int sent;
    int a;
    int b;
    for (int i = 0; i < 48; i++) pool[i] = {$urandom, $urandom};
    pool[0] = '0;
    pool[1] = '1;
    graph_nodes = 0;
    graph_edges = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (stim_table[i])
      send(stim_table[i].m, stim_table[i].k1, stim_table[i].k2, stim_table[i].want);
    sent = 0;
    while (sent < 1650) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send(dag_pkg::ModeClear, {$urandom, $urandom}, {$urandom, $urandom}, NoCheck);
      end else if (pick < 4) begin
        send(dag_pkg::ModeNop, {$urandom, $urandom}, {$urandom, $urandom}, NoCheck);
      end else if (pick < 34) begin
        random_key(k1);
        send(dag_pkg::ModeNode, k1, {$urandom, $urandom}, NoCheck);
      end else if (pick < 92 && graph_nodes > 1) begin
        a = $urandom_range(0, graph_nodes - 1);
        b = $urandom_range(0, graph_nodes - 1);
        if (a > b && $urandom_range(0, 3) != 0) begin
          pick = a;
          a = b;
          b = pick;
        end
        send(dag_pkg::ModeEdge, graph_keys[a], graph_keys[b], NoCheck);
      end else begin
        random_key(k1);
        random_key(k2);
        send(dag_pkg::ModeEdge, k1, k2, NoCheck);
      end
      sent++;
    end
    in_valid <= 1'b0;
    wait (status_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+sv
sv/dag_pkg.sv
sv/dag_ram.sv
sv/dag_datapath.sv
sv/dag_ctrl.sv
sv/dag_edge_insert_cycle_check_top.sv
sv/dag_checker.sv
test/tb.sv
